>>> hw/rtl/sriex_pkg.sv
// shared types and constants for the slot register integer execute unit
// no dependencies
`timescale 1ns / 1ps
package sriex_pkg;
    localparam int SLOT_COUNT = 256;
    localparam int SLOT_AW = 8;
    localparam int XLEN = 64;
    localparam int SW = 6; // step counter width

    typedef enum logic [4:0] {
        F_NIL = 5'd0, F_FALSE = 5'd1, F_TRUE = 5'd2, F_MOVE = 5'd3, F_ADDIMM = 5'd4,
        F_ADD = 5'd5, F_SUB = 5'd6, F_MUL = 5'd7, F_DIV = 5'd8, F_MOD = 5'd9,
        F_IMUL = 5'd10, F_IDIV = 5'd11, F_IMOD = 5'd12, F_AND = 5'd13, F_OR = 5'd14,
        F_XOR = 5'd15, F_NOT = 5'd16, F_SHL = 5'd17, F_SHR = 5'd18, F_LAND = 5'd19,
        F_LOR = 5'd20, F_LNOT = 5'd21, F_NEG = 5'd22, F_EQ = 5'd23, F_CMP = 5'd24,
        F_ICMP = 5'd25, F_GT = 5'd26, F_GTE = 5'd27, F_LT = 5'd28, F_LTE = 5'd29,
        F_ASSERT = 5'd30, F_TEST = 5'd31
    } func_t;

    typedef struct packed {
        logic start;
        logic is_div;    // 1 divide, 0 multiply
        logic is_signed;
    } iter_ctl_t;

    typedef struct packed {
        logic           done;
        logic [XLEN-1:0] lo;  // product or quotient
        logic [XLEN-1:0] hi;  // remainder
    } iter_sts_t;
endpackage

>>> hw/rtl/sriex_ram.sv
// generic single-port ram with registered read
// no dependencies
`timescale 1ns / 1ps
module sriex_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

>>> hw/rtl/sriex_iter.sv
// shared shift-add multiplier and restoring divider, one bit per cycle
// depends on sriex_pkg
`timescale 1ns / 1ps
module sriex_iter (
    input  logic                  clk,
    input  logic                  rst_n,
    input  sriex_pkg::iter_ctl_t  ctl,
    input  logic [sriex_pkg::XLEN-1:0] a,
    input  logic [sriex_pkg::XLEN-1:0] b,
    output sriex_pkg::iter_sts_t  sts
);
    localparam int XL = sriex_pkg::XLEN;
    logic [XL-1:0] acc_reg, acc_next, lo_reg, lo_next, b_reg, b_next;
    logic [sriex_pkg::SW-1:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next, div_reg, div_next, done_reg, done_next;
    logic [XL:0] trial;
    logic [XL-1:0] sum, ma, mb;

    always_comb
    begin
        ma = (ctl.is_signed && a[XL-1]) ? (~a + 1'b1) : a;
        mb = (ctl.is_signed && b[XL-1]) ? (~b + 1'b1) : b;
        trial = {acc_reg, lo_reg[XL-1]} - {1'b0, b_reg};
        sum = acc_reg + b_reg;
        acc_next = acc_reg;
        lo_next = lo_reg;
        b_next = b_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        div_next = div_reg;
        done_next = 1'b0;
        if (ctl.start)
        begin
            acc_next = '0;
            lo_next = ctl.is_div ? ma : a;
            b_next = ctl.is_div ? mb : b;
            div_next = ctl.is_div;
            cnt_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (div_reg)
            begin
                // restoring step: shift in next dividend bit
                if (!trial[XL])
                begin
                    acc_next = trial[XL-1:0];
                    lo_next = {lo_reg[XL-2:0], 1'b1};
                end
                else
                begin
                    acc_next = {acc_reg[XL-2:0], lo_reg[XL-1]};
                    lo_next = {lo_reg[XL-2:0], 1'b0};
                end
            end
            else
            begin
                // multiplier bit is lsb of lo, product accumulates low bits into acc
                if (lo_reg[0])
                begin
                    acc_next = acc_reg | '0;
                end
                lo_next = lo_reg >> 1;
                b_next = b_reg << 1;
                if (lo_reg[0])
                begin
                    acc_next = sum;
                end
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == sriex_pkg::SW'(XL - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
            div_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
            div_reg <= div_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        lo_reg <= lo_next;
        b_reg <= b_next;
    end

    assign sts.done = done_reg;
    assign sts.lo = div_reg ? lo_reg : acc_reg;
    assign sts.hi = acc_reg;
endmodule

>>> hw/rtl/slot_register_integer_execute_unit.sv
// top level: sequencer, slot file ram and result logic
// depends on sriex_pkg, sriex_ram, sriex_iter
`timescale 1ns / 1ps
// usage:
// s_axis carries one decoded instruction per transfer; m_axis returns one
// result per instruction. the block takes one instruction at a time:
// s_axis_tready is high only when the sequencer is idle and no result waits.
// simple ops pass through rda, rdb, getb, iter, wb and out, which raises
// m_axis_tvalid (two slot reads through the single ram port, a write-back
// and the result register). mul, imul, div, mod, idiv, imod also wait in
// iter for the shared one-bit-per-cycle multiply/divide unit.
// the result is held in the output register until m_axis_tready; a stalled
// receiver stalls the block.
// after reset a clearing pass writes zero to all 256 slots, one per cycle;
// no instruction is taken meanwhile.
// slots are read before the destination is written, so aliasing is safe.
module slot_register_integer_execute_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: dst_slot[7:0], src_a_slot[15:8], src_b_slot[23:16], immediate[55:24]
    input  logic [55:0] s_axis_tdata,
    // tuser: func[4:0]
    input  logic [4:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: written_value[63:0]
    output logic [63:0] m_axis_tdata,
    // tuser: wrote_slot[0], cond_false[1], assert_failed[2]
    output logic [2:0]  m_axis_tuser
);
    localparam int XL = sriex_pkg::XLEN;
    localparam int AW = sriex_pkg::SLOT_AW;

    typedef enum logic [7:0] {
        S_CLR = 8'b00000001, S_IDLE = 8'b00000010, S_RDA = 8'b00000100,
        S_RDB = 8'b00001000, S_GETB = 8'b00010000, S_ITER = 8'b00100000,
        S_WB = 8'b01000000, S_OUT = 8'b10000000
    } state_t;

    state_t state_reg, state_next;
    logic [AW:0] clr_reg, clr_next;
    sriex_pkg::func_t func_reg, func_next;
    logic [AW-1:0] dst_reg, dst_next, sb_reg, sb_next;
    logic [31:0] imm_reg, imm_next;
    logic [XL-1:0] a_reg, a_next, b_reg, b_next, v_reg, v_next;
    logic [2:0] ouser_reg, ouser_next;

    logic ram_we;
    logic [AW-1:0] ram_addr;
    logic [XL-1:0] ram_wdata, ram_rdata;
    sriex_pkg::iter_ctl_t ictl;
    sriex_pkg::iter_sts_t ists;

    logic [XL-1:0] alu;
    logic writes, is_iter, is_div, is_sgn;
    logic a_z, b_z, eq, ult, slt;
    logic [XL-1:0] q_fix, r_fix;
    logic min_ovf;

    sriex_ram #(.WIDTH(XL), .DEPTH(sriex_pkg::SLOT_COUNT)) u_ram (
        .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
    );

    sriex_iter u_iter (.clk(clk), .rst_n(rst_n), .ctl(ictl), .a(a_reg), .b(b_reg),
        .sts(ists));

    always_comb
    begin
        a_z = (a_reg == '0);
        b_z = (b_reg == '0);
        eq = (a_reg == b_reg);
        ult = (a_reg < b_reg);
        slt = ({~a_reg[XL-1], a_reg[XL-2:0]} < {~b_reg[XL-1], b_reg[XL-2:0]});
        min_ovf = (a_reg == {1'b1, {(XL-1){1'b0}}}) && (b_reg == '1);
        is_div = (func_reg == sriex_pkg::F_DIV) || (func_reg == sriex_pkg::F_MOD) ||
                 (func_reg == sriex_pkg::F_IDIV) || (func_reg == sriex_pkg::F_IMOD);
        is_sgn = (func_reg == sriex_pkg::F_IDIV) || (func_reg == sriex_pkg::F_IMOD);
        is_iter = is_div || (func_reg == sriex_pkg::F_MUL) ||
                  (func_reg == sriex_pkg::F_IMUL);
        writes = (func_reg != sriex_pkg::F_ASSERT) && (func_reg != sriex_pkg::F_TEST);
        q_fix = (is_sgn && (a_reg[XL-1] != b_reg[XL-1])) ? (~ists.lo + 1'b1) : ists.lo;
        r_fix = (is_sgn && a_reg[XL-1]) ? (~ists.hi + 1'b1) : ists.hi;
        unique case (func_reg)
            sriex_pkg::F_NIL, sriex_pkg::F_FALSE: alu = '0;
            sriex_pkg::F_TRUE: alu = XL'(1);
            sriex_pkg::F_MOVE: alu = a_reg;
            sriex_pkg::F_ADDIMM: alu = a_reg + {32'd0, imm_reg};
            sriex_pkg::F_ADD: alu = a_reg + b_reg;
            sriex_pkg::F_SUB: alu = a_reg - b_reg;
            sriex_pkg::F_MUL, sriex_pkg::F_IMUL: alu = ists.lo;
            sriex_pkg::F_DIV, sriex_pkg::F_IDIV:
                alu = b_z ? '1 : (is_sgn && min_ovf) ? a_reg : q_fix;
            sriex_pkg::F_MOD, sriex_pkg::F_IMOD:
                alu = b_z ? a_reg : (is_sgn && min_ovf) ? '0 : r_fix;
            sriex_pkg::F_AND: alu = a_reg & b_reg;
            sriex_pkg::F_OR: alu = a_reg | b_reg;
            sriex_pkg::F_XOR: alu = a_reg ^ b_reg;
            sriex_pkg::F_NOT: alu = ~a_reg;
            sriex_pkg::F_SHL: alu = a_reg << b_reg[5:0];
            sriex_pkg::F_SHR: alu = a_reg >> b_reg[5:0];
            sriex_pkg::F_LAND: alu = XL'(!a_z && !b_z);
            sriex_pkg::F_LOR: alu = XL'(!a_z || !b_z);
            sriex_pkg::F_LNOT: alu = XL'(a_z);
            sriex_pkg::F_NEG: alu = ~a_reg + 1'b1;
            sriex_pkg::F_EQ: alu = XL'(eq);
            sriex_pkg::F_CMP: alu = eq ? '0 : ult ? '1 : XL'(1);
            sriex_pkg::F_ICMP: alu = eq ? '0 : slt ? '1 : XL'(1);
            sriex_pkg::F_GT: alu = XL'(a_reg == XL'(1));
            sriex_pkg::F_GTE: alu = XL'(!a_reg[XL-1]);
            sriex_pkg::F_LT: alu = XL'(a_reg == '1);
            sriex_pkg::F_LTE: alu = XL'(a_reg[XL-1] || a_z);
            default: alu = '0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        clr_next = clr_reg;
        func_next = func_reg;
        dst_next = dst_reg;
        sb_next = sb_reg;
        imm_next = imm_reg;
        a_next = a_reg;
        b_next = b_reg;
        v_next = v_reg;
        ouser_next = ouser_reg;
        ram_we = 1'b0;
        ram_addr = dst_reg;
        ram_wdata = v_reg;
        ictl = '0;
        s_axis_tready = (state_reg == S_IDLE);
        unique case (state_reg)
            S_CLR:
            begin
                ram_we = 1'b1;
                ram_addr = clr_reg[AW-1:0];
                ram_wdata = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == (AW+1)'(sriex_pkg::SLOT_COUNT - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                ram_addr = s_axis_tdata[15:8];
                if (s_axis_tvalid)
                begin
                    func_next = sriex_pkg::func_t'(s_axis_tuser);
                    dst_next = s_axis_tdata[7:0];
                    sb_next = s_axis_tdata[23:16];
                    imm_next = s_axis_tdata[55:24];
                    state_next = S_RDA;
                end
            end
            S_RDA:
            begin
                // a data is on the ram output, issue b read now
                ram_addr = sb_reg;
                a_next = ram_rdata;
                state_next = S_RDB;
            end
            S_RDB:
            begin
                ram_addr = sb_reg;
                state_next = S_GETB;
            end
            S_GETB:
            begin
                b_next = ram_rdata;
                state_next = S_ITER;
            end
            S_ITER:
            begin
                if (is_iter && !ists.done)
                begin
                    ictl.start = (v_reg == '0) && !ouser_reg[0];
                    ictl.is_div = is_div;
                    ictl.is_signed = is_sgn;
                    ouser_next[0] = 1'b1; // started flag until write-back
                end
                else
                begin
                    v_next = writes ? alu : '0;
                    ouser_next = {(func_reg == sriex_pkg::F_ASSERT) && a_z,
                                  (func_reg == sriex_pkg::F_TEST) && a_z, writes};
                    state_next = S_WB;
                end
            end
            S_WB:
            begin
                ram_we = ouser_reg[0];
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (m_axis_tready)
                begin
                    v_next = '0;
                    ouser_next = '0;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            clr_reg <= '0;
            v_reg <= '0;
            ouser_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg <= clr_next;
            v_reg <= v_next;
            ouser_reg <= ouser_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg <= func_next;
        dst_reg <= dst_next;
        sb_reg <= sb_next;
        imm_reg <= imm_next;
        a_reg <= a_next;
        b_reg <= b_next;
    end

    assign m_axis_tvalid = (state_reg == S_OUT);
    assign m_axis_tdata = v_reg;
    assign m_axis_tuser = ouser_reg;

`ifndef NO_ASSERTIONS
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while result pending");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed under stall");
    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> $onehot0(m_axis_tuser))
        else $error("result flags not exclusive");
    a_nowrite_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
        else $error("value without write");
`endif
endmodule

>>> verif/sriex_checker.sv
// checker for the slot register integer execute unit: watches both streams,
// predicts each result from a private slot file and compares field by field
// depends on sriex_pkg
`timescale 1ns / 1ps
module sriex_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,
    input  logic [4:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [63:0] m_axis_tdata,
    input  logic [2:0]  m_axis_tuser,
    output int          fail_count,
    output int          pending
);
    typedef struct packed {
        logic [63:0] value;
        logic [2:0]  flags; // wrote_slot, cond_false, assert_failed from bit 0
    } outcome_t;

    logic [63:0] shadow_slots [sriex_pkg::SLOT_COUNT];
    outcome_t    outcome_q [$];

    assign pending = outcome_q.size();

    function automatic logic [63:0] three_way(logic eq, logic lt);
        if (eq) return 64'd0;
        return lt ? '1 : 64'd1;
    endfunction

    function automatic logic [63:0] abs64(logic [63:0] v);
        return v[63] ? -v : v;
    endfunction

    task automatic execute(input sriex_pkg::func_t f, input logic [55:0] d);
        logic [7:0]  dst;
        logic [63:0] a, b, v, q, r;
        logic        wr, cf, af;
        outcome_t    o;
        dst = d[7:0];
        a = shadow_slots[d[15:8]];
        b = shadow_slots[d[23:16]];
        v = '0; wr = 1'b1; cf = 1'b0; af = 1'b0;
        case (f)
            sriex_pkg::F_NIL, sriex_pkg::F_FALSE: v = '0;
            sriex_pkg::F_TRUE:   v = 64'd1;
            sriex_pkg::F_MOVE:   v = a;
            sriex_pkg::F_ADDIMM: v = a + {32'd0, d[55:24]};
            sriex_pkg::F_ADD:    v = a + b;
            sriex_pkg::F_SUB:    v = a - b;
            sriex_pkg::F_MUL, sriex_pkg::F_IMUL: v = a * b;
            sriex_pkg::F_DIV:    v = (b == 0) ? '1 : a / b;
            sriex_pkg::F_MOD:    v = (b == 0) ? a : a % b;
            sriex_pkg::F_IDIV:
            begin
                if (b == 0) v = '1;
                else if (a == {1'b1, 63'd0} && b == '1) v = a;
                else
                begin
                    q = abs64(a) / abs64(b);
                    v = (a[63] != b[63]) ? -q : q;
                end
            end
            sriex_pkg::F_IMOD:
            begin
                if (b == 0) v = a;
                else if (a == {1'b1, 63'd0} && b == '1) v = '0;
                else
                begin
                    r = abs64(a) % abs64(b);
                    v = a[63] ? -r : r;
                end
            end
            sriex_pkg::F_AND:  v = a & b;
            sriex_pkg::F_OR:   v = a | b;
            sriex_pkg::F_XOR:  v = a ^ b;
            sriex_pkg::F_NOT:  v = ~a;
            sriex_pkg::F_SHL:  v = a << b[5:0];
            sriex_pkg::F_SHR:  v = a >> b[5:0];
            sriex_pkg::F_LAND: v = {63'd0, (a != 0) && (b != 0)};
            sriex_pkg::F_LOR:  v = {63'd0, (a != 0) || (b != 0)};
            sriex_pkg::F_LNOT: v = {63'd0, a == 0};
            sriex_pkg::F_NEG:  v = -a;
            sriex_pkg::F_EQ:   v = {63'd0, a == b};
            sriex_pkg::F_CMP:  v = three_way(a == b, a < b);
            sriex_pkg::F_ICMP: v = three_way(a == b, $signed(a) < $signed(b));
            sriex_pkg::F_GT:   v = {63'd0, a == 64'd1};
            sriex_pkg::F_GTE:  v = {63'd0, !a[63]};
            sriex_pkg::F_LT:   v = {63'd0, a == '1};
            sriex_pkg::F_LTE:  v = {63'd0, a[63] || a == 0};
            sriex_pkg::F_ASSERT:
            begin
                wr = 1'b0;
                af = (a == 0);
            end
            default:
            begin
                wr = 1'b0;
                cf = (a == 0);
            end
        endcase
        if (wr) shadow_slots[dst] = v;
        else v = '0;
        o.value = v;
        o.flags = {af, cf, wr};
        outcome_q.push_back(o);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t exp_o;
        if (!rst_n)
        begin
            for (int i = 0; i < sriex_pkg::SLOT_COUNT; i++) shadow_slots[i] = '0;
            outcome_q.delete();
            fail_count = 0;
        end
        else
        begin
            // result side first: a new instruction cannot finish in the same cycle
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (outcome_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result value=%h flags=%b",
                                 m_axis_tdata, m_axis_tuser);
                end
                else
                begin
                    exp_o = outcome_q.pop_front();
                    if (exp_o.value !== m_axis_tdata || exp_o.flags !== m_axis_tuser)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: exp value=%h flags=%b got value=%h flags=%b",
                                     exp_o.value, exp_o.flags, m_axis_tdata, m_axis_tuser);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                execute(sriex_pkg::func_t'(s_axis_tuser), s_axis_tdata);
        end
    end
endmodule

>>> verif/tb_slot_register_integer_execute_unit.sv
// stimulus top for the slot register integer execute unit
// depends on sriex_pkg, the block and sriex_checker
`timescale 1ns / 1ps
module tb_slot_register_integer_execute_unit;
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata = '0;
    logic [4:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    int          fail_count;
    int          pending;
    int          src_idle_pct = 0;
    int          sink_stall_pct = 0;
    int          hold_off = 0;
    int          cycle_count = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    slot_register_integer_execute_unit u_dut (.*);

    sriex_checker u_chk (.*);

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 2000000)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver: random stall, or a long hold-off counted here
    always @(posedge clk)
    begin
        if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    logic [63:0] seed_vals [8] = '{64'd0, 64'd1, '1, {1'b1, 63'd0}, {1'b0, {63{1'b1}}},
                                   64'd63, 64'd64, 64'h0123_4567_89ab_cdef};

    // one instruction transfer; random sender gaps before it
    task automatic send(input sriex_pkg::func_t f, input logic [7:0] dst,
                        input logic [7:0] sa, input logic [7:0] sb,
                        input logic [31:0] imm);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= f;
        s_axis_tdata  <= {imm, sb, sa, dst};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
    endtask

    // load a 64-bit value into a slot through addimm and shifts
    task automatic load_slot(input logic [7:0] s, input logic [63:0] v, input logic [7:0] t);
        send(sriex_pkg::F_NIL, t, 8'd0, 8'd0, 32'd0);
        send(sriex_pkg::F_ADDIMM, t, t, t, 32'd32);
        send(sriex_pkg::F_ADDIMM, s, t, t, v[63:32] - 32'd32);
        send(sriex_pkg::F_SHL, s, s, t, 32'd0);
        send(sriex_pkg::F_ADDIMM, s, s, s, v[31:0]);
    endtask

    initial
    begin
        sriex_pkg::func_t f;
        int ph;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: fill a few slots with edge values, then every operation
        for (int i = 0; i < 4; i++) load_slot(8'(10 + i), seed_vals[i], 8'd255);
        send(sriex_pkg::F_TRUE, 8'd20, 8'd0, 8'd0, 32'd0);
        send(sriex_pkg::F_DIV, 8'd21, 8'd12, 8'd0, 32'd0);
        send(sriex_pkg::F_IMOD, 8'd22, 8'd13, 8'd12, 32'd0);
        send(sriex_pkg::F_IDIV, 8'd23, 8'd13, 8'd12, 32'd0);
        send(sriex_pkg::F_MOD, 8'd24, 8'd12, 8'd0, 32'd0);
        send(sriex_pkg::F_ADD, 8'd12, 8'd12, 8'd12, 32'd0);
        send(sriex_pkg::F_ASSERT, 8'd0, 8'd0, 8'd0, 32'd0);
        send(sriex_pkg::F_TEST, 8'd0, 8'd11, 8'd0, 32'd0);
        send(sriex_pkg::F_ADDIMM, 8'd25, 8'd12, 8'd0, 32'hffff_ffff);
        for (int k = 0; k < 32; k++)
            send(sriex_pkg::func_t'(k), 8'(30 + k), 8'(10 + k % 4), 8'(13 - k % 4), 32'd0);

        for (ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 48; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 48; end
                3: begin src_idle_pct = 14; sink_stall_pct = 14; end
                default: begin src_idle_pct = 0; sink_stall_pct = 0; hold_off = 400; end
            endcase
            for (int n = 0; n < 220; n++)
            begin
                if ($urandom_range(9) == 0)
                    load_slot(8'($urandom_range(15)), seed_vals[$urandom_range(7)] ^
                              ({$urandom, $urandom} & {64{1'($urandom_range(1))}}),
                              8'd200);
                else
                begin
                    f = sriex_pkg::func_t'($urandom_range(31));
                    send(f, 8'($urandom_range(1) ? $urandom_range(15) : $urandom_range(255)),
                         8'($urandom_range(3) ? $urandom_range(15) : $urandom_range(255)),
                         8'($urandom_range(3) ? $urandom_range(15) : $urandom_range(255)),
                         $urandom);
                end
            end
        end
        s_axis_tvalid <= 1'b0;

        while (pending > 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
